>>> rtl/harq_rx_pkg.sv
// Shared types and codes for the receive HARQ process.
package harq_rx_pkg;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_FEEDBACK = 2'd1,
    OP_EXTRACT  = 2'd2,
    OP_QUERY    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_NEW_BUSY  = 3'd1,
    ERR_RETX_BUSY = 3'd2,
    ERR_NOT_EVAL  = 3'd3,
    ERR_NOT_OK    = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    UNIT_EMPTY = 2'd0,
    UNIT_EVAL  = 2'd1,
    UNIT_OK    = 2'd2,
    UNIT_BAD   = 2'd3
  } unit_t;

  typedef enum logic [1:0] {
    REG_MAX_RETX   = 2'd0,
    REG_EVAL_TIMER = 2'd1,
    REG_IS_BS      = 2'd2,
    REG_PROCESS_ID = 2'd3
  } reg_idx_t;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [3:0] MAX_RETX_RST   = 4'd3;
  localparam logic [3:0] EVAL_TIMER_RST = 4'd4;
  localparam logic       IS_BS_RST      = 1'b1;
  localparam logic [3:0] PROCESS_ID_RST = 4'd0;
  localparam logic [3:0] TX_COUNT_MAX   = 4'hF;

  typedef struct packed {
    logic [3:0] max_retx;
    logic [3:0] eval_timer;
    logic       is_bs;
    logic [3:0] process_id;
  } cfg_t;

  typedef struct packed {
    logic load;  // capture input word
    logic exec;  // apply captured word, load result register
  } cmd_t;

endpackage

>>> rtl/harq_rx_regs.sv
// Configuration register bank behind the APB-style port.
module harq_rx_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [harq_rx_pkg::ADDR_W-1:0] paddr,
  input  logic [harq_rx_pkg::DATA_W-1:0] pwdata,
  output logic [harq_rx_pkg::DATA_W-1:0] prdata,
  output logic                          pready,
  output harq_rx_pkg::cfg_t             cfg
);
  import harq_rx_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_retx   <= MAX_RETX_RST;
      cfg.eval_timer <= EVAL_TIMER_RST;
      cfg.is_bs      <= IS_BS_RST;
      cfg.process_id <= PROCESS_ID_RST;
    end else if (wr_en) begin
      case (idx)
        REG_MAX_RETX:   cfg.max_retx   <= pwdata[3:0];
        REG_EVAL_TIMER: cfg.eval_timer <= pwdata[3:0];
        REG_IS_BS:      cfg.is_bs      <= pwdata[0];
        REG_PROCESS_ID: cfg.process_id <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_MAX_RETX:   prdata[3:0] = cfg.max_retx;
      REG_EVAL_TIMER: prdata[3:0] = cfg.eval_timer;
      REG_IS_BS:      prdata[0]   = cfg.is_bs;
      REG_PROCESS_ID: prdata[3:0] = cfg.process_id;
      default:        prdata      = '0;
    endcase
  end

endmodule

>>> rtl/harq_rx_ctrl.sv
// Controller: input capture, execute step and result register handshake.
module harq_rx_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output harq_rx_pkg::cmd_t cmd
);
  import harq_rx_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;
  logic   out_free;

  // result register can take a new word this cycle
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state == ST_EXEC) && !out_free;
  assign cmd.load = in_valid && !in_stall;
  assign cmd.exec = (state == ST_EXEC) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: if (cmd.load) state <= ST_EXEC;
        ST_EXEC: if (cmd.exec && !cmd.load) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/harq_rx_dp.sv
// Datapath: unit store, transmission counter, step logic and result register.
module harq_rx_dp #(
  parameter int CODEWORDS = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  harq_rx_pkg::cmd_t cmd,
  input  harq_rx_pkg::cfg_t cfg,
  input  logic [1:0]        op,
  input  logic              codeword,
  input  logic              new_data,
  input  logic              decode_ok,
  input  logic [15:0]       pdu_tag,
  input  logic [31:0]       now_slot,
  output logic [2:0]        error_code,
  output logic              feedback_valid,
  output logic              ack,
  output logic [3:0]        fb_process,
  output logic              codeword_out,
  output logic [15:0]       tag_out,
  output logic              retx_request,
  output logic              purged,
  output logic              extracted,
  output logic [1:0]        unit_state,
  output logic              evaluated,
  output logic              process_active
);
  import harq_rx_pkg::*;

  localparam int CW_W = (CODEWORDS > 1) ? $clog2(CODEWORDS) : 1;

  // captured input word
  op_t             op_r;
  logic [CW_W-1:0] idx;
  logic            new_data_r;
  logic            decode_ok_r;
  logic [15:0]     tag_r;
  logic [31:0]     now_r;

  // unit store
  unit_t       status      [CODEWORDS];
  logic [31:0] arrival     [CODEWORDS];
  logic        decode_res  [CODEWORDS];
  logic [15:0] stored_tag  [CODEWORDS];
  logic [3:0]  tx_count;

  unit_t       status_next [CODEWORDS];
  logic [3:0]  tx_count_next;
  logic        wr_ins;
  unit_t       st;
  logic [31:0] elapsed;
  logic [3:0]  need;
  logic        done_pre;
  logic        done_post;
  logic        active_c;
  err_t        err_c;
  logic        fbv_c;
  logic        ack_c;
  logic [3:0]  fbp_c;
  logic [15:0] tout_c;
  logic        retx_c;
  logic        purged_c;
  logic        extr_c;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= op_t'(op);
      idx         <= (CODEWORDS > 1) ? CW_W'(codeword) : '0;
      new_data_r  <= new_data;
      decode_ok_r <= decode_ok;
      tag_r       <= pdu_tag;
      now_r       <= now_slot;
    end
  end

  assign st       = status[idx];
  assign elapsed  = now_r - arrival[idx];
  assign need     = (cfg.eval_timer == 4'd0) ? 4'd0 : cfg.eval_timer - 4'd1;
  assign done_pre = (st == UNIT_EVAL) && (elapsed >= {28'd0, need});

  always_comb begin
    for (int k = 0; k < CODEWORDS; k++) status_next[k] = status[k];
    tx_count_next = tx_count;
    wr_ins   = 1'b0;
    err_c    = ERR_OK;
    fbv_c    = 1'b0;
    ack_c    = 1'b0;
    fbp_c    = '0;
    tout_c   = '0;
    retx_c   = 1'b0;
    purged_c = 1'b0;
    extr_c   = 1'b0;
    case (op_r)
      OP_INSERT: begin
        if (new_data_r && st != UNIT_EMPTY) begin
          err_c = ERR_NEW_BUSY;
        end else if (!new_data_r && st != UNIT_EMPTY && st != UNIT_BAD) begin
          err_c = ERR_RETX_BUSY;
        end else begin
          wr_ins = 1'b1;
          status_next[idx] = UNIT_EVAL;
          if (tx_count != TX_COUNT_MAX) tx_count_next = tx_count + 4'd1;
        end
      end
      OP_FEEDBACK: begin
        if (!done_pre) begin
          err_c = ERR_NOT_EVAL;
        end else begin
          fbv_c  = 1'b1;
          ack_c  = decode_res[idx];
          fbp_c  = cfg.process_id;
          tout_c = stored_tag[idx];
          if (!ack_c) begin
            // purge only on an exact match with the limit
            if ({1'b0, tx_count} == {1'b0, cfg.max_retx} + 5'd1) begin
              status_next[idx] = UNIT_EMPTY;
              tx_count_next    = '0;
              purged_c         = 1'b1;
            end else begin
              status_next[idx] = UNIT_BAD;
              retx_c           = cfg.is_bs;
            end
          end else begin
            status_next[idx] = UNIT_OK;
          end
        end
      end
      OP_EXTRACT: begin
        if (st != UNIT_OK) begin
          err_c = ERR_NOT_OK;
        end else begin
          tout_c           = stored_tag[idx];
          extr_c           = 1'b1;
          status_next[idx] = UNIT_EMPTY;
          tx_count_next    = '0;
        end
      end
      OP_QUERY: ;
      default: ;
    endcase
  end

  // a fresh insert has zero elapsed slots; otherwise the unit is unchanged if still evaluating
  assign done_post = (status_next[idx] == UNIT_EVAL) &&
                     (wr_ins ? (need == 4'd0) : done_pre);

  always_comb begin
    active_c = 1'b0;
    for (int k = 0; k < CODEWORDS; k++) begin
      if (status_next[k] != UNIT_EMPTY) active_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CODEWORDS; k++) status[k] <= UNIT_EMPTY;
      tx_count <= '0;
    end else if (cmd.exec) begin
      for (int k = 0; k < CODEWORDS; k++) status[k] <= status_next[k];
      tx_count <= tx_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_ins) begin
      arrival[idx]    <= now_r;
      decode_res[idx] <= decode_ok_r;
      stored_tag[idx] <= tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      error_code     <= err_c;
      feedback_valid <= fbv_c;
      ack            <= ack_c;
      fb_process     <= fbp_c;
      codeword_out   <= idx[0];
      tag_out        <= tout_c;
      retx_request   <= retx_c;
      purged         <= purged_c;
      extracted      <= extr_c;
      unit_state     <= status_next[idx];
      evaluated      <= done_post;
      process_active <= active_c;
    end
  end

endmodule

>>> rtl/harq_receive_process.sv
// Top level of the receive HARQ process.
// One receive HARQ process with CODEWORDS units. Each accepted word (insert, feedback,
// extract or status query) yields exactly one result word: the input register captures it,
// then the execute step loads the result into the output register once any stalled result
// there is taken. With the result side not stalling, a new word is accepted every cycle,
// set by the input capture register and one execute stage (the 32-bit elapsed-slot subtract
// and compare against the evaluation timer). A pending result is held in the output register
// while the next word is captured. Configuration registers sit at byte addresses 0, 4, 8
// and 12; the user must write them only while idle, and the block does not enforce this.
module harq_receive_process #(
  parameter int CODEWORDS = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [harq_rx_pkg::ADDR_W-1:0] paddr,
  input  logic [harq_rx_pkg::DATA_W-1:0] pwdata,
  output logic [harq_rx_pkg::DATA_W-1:0] prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic                          codeword,
  input  logic                          new_data,
  input  logic                          decode_ok,
  input  logic [15:0]                   pdu_tag,
  input  logic [31:0]                   now_slot,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    error_code,
  output logic                          feedback_valid,
  output logic                          ack,
  output logic [3:0]                    fb_process,
  output logic                          codeword_out,
  output logic [15:0]                   tag_out,
  output logic                          retx_request,
  output logic                          purged,
  output logic                          extracted,
  output logic [1:0]                    unit_state,
  output logic                          evaluated,
  output logic                          process_active
);
  import harq_rx_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  harq_rx_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  harq_rx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  harq_rx_dp #(
    .CODEWORDS (CODEWORDS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .op             (op),
    .codeword       (codeword),
    .new_data       (new_data),
    .decode_ok      (decode_ok),
    .pdu_tag        (pdu_tag),
    .now_slot       (now_slot),
    .error_code     (error_code),
    .feedback_valid (feedback_valid),
    .ack            (ack),
    .fb_process     (fb_process),
    .codeword_out   (codeword_out),
    .tag_out        (tag_out),
    .retx_request   (retx_request),
    .purged         (purged),
    .extracted      (extracted),
    .unit_state     (unit_state),
    .evaluated      (evaluated),
    .process_active (process_active)
  );

endmodule

>>> rtl/harq_rx_checker.sv
// Port-level checks on the result channel of the receive HARQ process, with bind.
module harq_rx_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  error_code,
  input logic        feedback_valid,
  input logic        ack,
  input logic        retx_request,
  input logic        purged,
  input logic        extracted,
  input logic [1:0]  unit_state,
  input logic        process_active
);
  import harq_rx_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // a rejected request reports no action
  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_OK |->
      !feedback_valid && !extracted && !purged && !retx_request)
    else $error("action reported alongside an error");

  // a purge follows a NACK and leaves the unit empty
  a_purge: assert property (@(posedge clk) disable iff (rst)
    out_valid && purged |->
      feedback_valid && !ack && !retx_request && unit_state == UNIT_EMPTY)
    else $error("inconsistent purge result");

  // an extract leaves the unit empty
  a_extract: assert property (@(posedge clk) disable iff (rst)
    out_valid && extracted |-> !feedback_valid && unit_state == UNIT_EMPTY)
    else $error("inconsistent extract result");

  // a unit that is not empty keeps the process active
  a_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && unit_state != UNIT_EMPTY |-> process_active)
    else $error("process inactive with an occupied unit");

endmodule

bind harq_receive_process harq_rx_checker u_harq_rx_checker (.*);

>>> sim/harq_checker.sv
// Scoreboard for the receive HARQ process: watches both channels and the register port.
module harq_checker
  import harq_rx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        op,
  input  logic              codeword,
  input  logic              new_data,
  input  logic              decode_ok,
  input  logic [15:0]       pdu_tag,
  input  logic [31:0]       now_slot,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [2:0]        error_code,
  input  logic              feedback_valid,
  input  logic              ack,
  input  logic [3:0]        fb_process,
  input  logic              codeword_out,
  input  logic [15:0]       tag_out,
  input  logic              retx_request,
  input  logic              purged,
  input  logic              extracted,
  input  logic [1:0]        unit_state,
  input  logic              evaluated,
  input  logic              process_active,
  output int                fails,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    err_t        err;
    logic        fb;
    logic        ack;
    logic [3:0]  proc_id;
    logic        cw;
    logic [15:0] tag;
    logic        retx;
    logic        purge;
    logic        extract;
    unit_t       ustate;
    logic        ready;
    logic        active;
  } harq_result_t;

  cfg_t         cfg;
  unit_t        status   [2];
  logic [31:0]  arrival  [2];
  logic         decoded  [2];
  logic [15:0]  held_tag [2];
  logic [3:0]   tx_cnt;
  harq_result_t due_results [$];

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns  %s: got %0h, expected %0h", $time, what, got, want);
    fails++;
  endtask

  function automatic logic fb_allowed(int u, logic [31:0] now);
    logic [3:0]  need;
    logic [31:0] gone;
    need = (cfg.eval_timer == 4'd0) ? 4'd0 : cfg.eval_timer - 4'd1;
    gone = now - arrival[u];
    return status[u] == UNIT_EVAL && gone >= {28'd0, need};
  endfunction

  function automatic void drop_unit(int u);
    status[u]  = UNIT_EMPTY;
    arrival[u] = '0;
    decoded[u] = 1'b0;
    tx_cnt     = '0;
  endfunction

  function automatic harq_result_t step_process(op_t o, int u, logic nd, logic dok,
                                                logic [15:0] tag, logic [31:0] now);
    harq_result_t r;
    r     = '0;
    r.err = ERR_OK;
    r.cw  = u[0];
    case (o)
      OP_INSERT: begin
        if (nd && status[u] != UNIT_EMPTY) begin
          r.err = ERR_NEW_BUSY;
        end else if (!nd && status[u] != UNIT_EMPTY && status[u] != UNIT_BAD) begin
          r.err = ERR_RETX_BUSY;
        end else begin
          held_tag[u] = tag;
          decoded[u]  = dok;
          status[u]   = UNIT_EVAL;
          arrival[u]  = now;
          if (tx_cnt != TX_COUNT_MAX) tx_cnt++;
        end
      end
      OP_FEEDBACK: begin
        if (!fb_allowed(u, now)) begin
          r.err = ERR_NOT_EVAL;
        end else begin
          r.fb      = 1'b1;
          r.ack     = decoded[u];
          r.proc_id = cfg.process_id;
          r.tag     = held_tag[u];
          if (r.ack) begin
            status[u] = UNIT_OK;
          end else begin
            status[u] = UNIT_BAD;
            // purge only on an exact match, so a limit of 15 never purges
            if ({1'b0, tx_cnt} == {1'b0, cfg.max_retx} + 5'd1) begin
              drop_unit(u);
              r.purge = 1'b1;
            end else begin
              r.retx = cfg.is_bs;
            end
          end
        end
      end
      OP_EXTRACT: begin
        if (status[u] != UNIT_OK) begin
          r.err = ERR_NOT_OK;
        end else begin
          r.tag     = held_tag[u];
          r.extract = 1'b1;
          drop_unit(u);
        end
      end
      default: ;
    endcase
    r.ustate = status[u];
    r.ready  = fb_allowed(u, now);
    r.active = status[0] != UNIT_EMPTY || status[1] != UNIT_EMPTY;
    return r;
  endfunction

  always @(posedge clk) begin
    harq_result_t seen;
    harq_result_t want;
    if (rst) begin
      cfg = '{MAX_RETX_RST, EVAL_TIMER_RST, IS_BS_RST, PROCESS_ID_RST};
      for (int u = 0; u < 2; u++) begin
        status[u]   = UNIT_EMPTY;
        arrival[u]  = '0;
        decoded[u]  = 1'b0;
        held_tag[u] = '0;
      end
      tx_cnt = '0;
      due_results.delete();
    end else begin
      // results first: a word accepted at this edge cannot have its result out yet
      if (out_valid && !out_stall) begin
        seen = {err_t'(error_code), feedback_valid, ack, fb_process, codeword_out, tag_out,
                retx_request, purged, extracted, unit_t'(unit_state), evaluated,
                process_active};
        if (due_results.size() == 0) begin
          report("result word with nothing expected", seen[31:0], '0);
        end else begin
          want = due_results.pop_front();
          if (seen.err !== want.err)
            report("error_code", 32'(seen.err), 32'(want.err));
          if (seen.fb !== want.fb)
            report("feedback_valid", 32'(seen.fb), 32'(want.fb));
          if (seen.ack !== want.ack)
            report("ack", 32'(seen.ack), 32'(want.ack));
          if (seen.proc_id !== want.proc_id)
            report("fb_process", 32'(seen.proc_id), 32'(want.proc_id));
          if (seen.cw !== want.cw)
            report("codeword_out", 32'(seen.cw), 32'(want.cw));
          if (seen.tag !== want.tag)
            report("tag_out", 32'(seen.tag), 32'(want.tag));
          if (seen.retx !== want.retx)
            report("retx_request", 32'(seen.retx), 32'(want.retx));
          if (seen.purge !== want.purge)
            report("purged", 32'(seen.purge), 32'(want.purge));
          if (seen.extract !== want.extract)
            report("extracted", 32'(seen.extract), 32'(want.extract));
          if (seen.ustate !== want.ustate)
            report("unit_state", 32'(seen.ustate), 32'(want.ustate));
          if (seen.ready !== want.ready)
            report("evaluated", 32'(seen.ready), 32'(want.ready));
          if (seen.active !== want.active)
            report("process_active", 32'(seen.active), 32'(want.active));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_MAX_RETX:   cfg.max_retx   = pwdata[3:0];
          REG_EVAL_TIMER: cfg.eval_timer = pwdata[3:0];
          REG_IS_BS:      cfg.is_bs      = pwdata[0];
          REG_PROCESS_ID: cfg.process_id = pwdata[3:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        due_results = {due_results, step_process(op_t'(op), int'(codeword), new_data,
                                                 decode_ok, pdu_tag, now_slot)};
    end
    pending = due_results.size();
  end

endmodule

>>> sim/tb.sv
// Testbench top for the receive HARQ process: stimulus, register setup and verdict.
module tb;
  import harq_rx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 200000;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic              in_valid, in_stall;
  logic [1:0]        op;
  logic              codeword, new_data, decode_ok;
  logic [15:0]       pdu_tag;
  logic [31:0]       now_slot;
  logic              out_valid, out_stall;
  logic [2:0]        error_code;
  logic              feedback_valid, ack;
  logic [3:0]        fb_process;
  logic              codeword_out;
  logic [15:0]       tag_out;
  logic              retx_request, purged, extracted;
  logic [1:0]        unit_state;
  logic              evaluated, process_active;
  int                fails, pending;

  logic [31:0] slot_now;
  logic [3:0]  timer_now;
  int          ok_pct;
  bit          calm;
  int          sent;
  int          cycles;

  harq_receive_process #(.CODEWORDS(2)) dut (.*);
  harq_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= !calm && $urandom_range(0, 99) < 11;

  task automatic send(op_t o, logic cw, logic nd, logic dok, logic [15:0] tag,
                      logic [31:0] slot);
    if (!calm && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= o;
    codeword  <= cw;
    new_data  <= nd;
    decode_ok <= dok;
    pdu_tag   <= tag;
    now_slot  <= slot;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic configure(logic [3:0] retx_max, logic [3:0] timer, logic bs,
                           logic [3:0] pid);
    logic [3:0] vals [4];
    vals = '{retx_max, timer, {3'b000, bs}, pid};
    for (int i = 0; i < 4; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx_t'(i), 2'b00};
      pwdata  <= {28'd0, vals[i]};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel      <= 1'b0;
    penable   <= 1'b0;
    timer_now = timer;
  endtask

  function automatic logic [31:0] need_slots();
    return (timer_now == 4'd0) ? 32'd0 : {28'd0, timer_now - 4'd1};
  endfunction

  // one data unit from first transmission to release, with NACK rounds in between
  task automatic transfer(logic cw);
    int   tries;
    logic dok;
    logic nd;
    tries = $urandom_range(1, 18);
    for (int i = 0; i < tries; i++) begin
      dok = (i == tries - 1) ? 1'b1 : ($urandom_range(0, 99) < ok_pct);
      nd  = (i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 19) == 0);
      slot_now += $urandom_range(0, 2);
      send(OP_INSERT, cw, nd, dok, 16'($urandom), slot_now);
      if ($urandom_range(0, 99) < 15)
        send(OP_FEEDBACK, cw, 1'($urandom), 1'($urandom), 16'($urandom), slot_now);
      if ($urandom_range(0, 99) < 10)
        send(OP_QUERY, cw, 1'($urandom), 1'($urandom), 16'($urandom), slot_now);
      slot_now += need_slots() + $urandom_range(0, 3);
      send(OP_FEEDBACK, cw, 1'($urandom), 1'($urandom), 16'($urandom), slot_now);
      if (dok) break;
    end
    send(OP_EXTRACT, cw, 1'($urandom), 1'($urandom), 16'($urandom), slot_now);
  endtask

  task automatic noise();
    logic [31:0] slot;
    slot = $urandom_range(0, 1) ? $urandom : slot_now + $urandom_range(0, 20);
    send(op_t'($urandom_range(0, 3)), 1'($urandom), 1'($urandom), 1'($urandom),
         16'($urandom), slot);
  endtask

  initial begin
    int goal;
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_valid  = 1'b0;
    op        = OP_QUERY;
    codeword  = 1'b0;
    new_data  = 1'b0;
    decode_ok = 1'b0;
    pdu_tag   = '0;
    now_slot  = '0;
    out_stall = 1'b0;
    timer_now = EVAL_TIMER_RST;
    ok_pct    = 50;
    calm      = 1'b0;
    sent      = 0;
    cycles    = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: error paths, slot wrap, purge at the limit, ACK and release
    send(OP_QUERY,    1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000);
    send(OP_EXTRACT,  1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000);
    send(OP_FEEDBACK, 1'b1, 1'b0, 1'b0, 16'h0000, 32'h0000_0000);
    send(OP_INSERT,   1'b0, 1'b1, 1'b0, 16'hFFFF, 32'hFFFF_FFFE);
    send(OP_INSERT,   1'b0, 1'b1, 1'b1, 16'h1234, 32'hFFFF_FFFE);
    send(OP_INSERT,   1'b0, 1'b0, 1'b1, 16'h4321, 32'hFFFF_FFFF);
    send(OP_FEEDBACK, 1'b0, 1'b0, 1'b0, 16'h0000, 32'hFFFF_FFFF);
    send(OP_FEEDBACK, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0001);
    send(OP_EXTRACT,  1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0001);
    send(OP_INSERT,   1'b0, 1'b1, 1'b0, 16'h0F0F, 32'h0000_0002);
    send(OP_INSERT,   1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0002);
    send(OP_FEEDBACK, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0005);
    send(OP_INSERT,   1'b0, 1'b0, 1'b0, 16'h00FF, 32'h0000_0006);
    send(OP_FEEDBACK, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0009);
    send(OP_INSERT,   1'b0, 1'b0, 1'b0, 16'hFF00, 32'h0000_000A);
    send(OP_FEEDBACK, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_000D);
    send(OP_INSERT,   1'b1, 1'b1, 1'b1, 16'hA5A5, 32'h0000_000E);
    send(OP_INSERT,   1'b0, 1'b1, 1'b1, 16'h5A5A, 32'h0000_000F);
    send(OP_QUERY,    1'b1, 1'b0, 1'b0, 16'h0000, 32'h0000_0011);
    send(OP_FEEDBACK, 1'b1, 1'b0, 1'b0, 16'h0000, 32'h0000_0011);
    send(OP_INSERT,   1'b1, 1'b0, 1'b1, 16'h7777, 32'h0000_0012);
    send(OP_EXTRACT,  1'b1, 1'b0, 1'b0, 16'h0000, 32'h0000_0012);
    send(OP_FEEDBACK, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h8000_0000);
    send(OP_EXTRACT,  1'b0, 1'b0, 1'b0, 16'h0000, 32'h8000_0000);
    send(OP_QUERY,    1'b1, 1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);

    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      calm = (phase == 2);
      case (phase)
        0: begin
          configure(4'd0, 4'd0, 1'b1, 4'd15);
          ok_pct   = 50;
          slot_now = $urandom;
        end
        1: begin
          configure(4'd14, 4'd15, 1'b0, 4'd5);
          ok_pct   = 10;
          slot_now = 32'hFFFF_FF80;
        end
        2: begin
          configure(4'd15, 4'd1, 1'b1, 4'd10);
          ok_pct   = 30;
          slot_now = $urandom;
        end
        3: begin
          configure(4'd3, 4'd4, 1'b0, 4'd0);
          ok_pct   = 70;
          slot_now = $urandom;
        end
        4: begin
          configure(4'd7, 4'd8, 1'b1, 4'd9);
          ok_pct   = 40;
          slot_now = $urandom;
        end
        default: begin
          configure(4'($urandom), 4'($urandom), 1'($urandom), 4'($urandom));
          ok_pct   = $urandom_range(5, 90);
          slot_now = $urandom;
        end
      endcase
      goal = sent + 130;
      while (sent < goal) begin
        if ($urandom_range(0, 9) < 7) transfer(1'($urandom));
        else noise();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
